[rtl/core/fbfla_pkg.sv]
// fbfla_pkg: shared widths, codes and controller/datapath interface structs
// for the fixed block free-list allocator. No dependencies.
`timescale 1ns / 1ps

package fbfla_pkg;

    // pool geometry defaults
    localparam int MAX_BLOCKS_DEF = 256;
    localparam int WORD_BYTES     = 8;

    // port widths
    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int OFFSET_W   = 20;
    localparam int COUNT_W    = 9;
    localparam int NBLK_W     = 9;
    localparam int BBYTES_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register reset values
    localparam logic [NBLK_W-1:0]   NBLK_RST   = 9'd256;
    localparam logic [BBYTES_W-1:0] BBYTES_RST = 13'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INIT  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;     // latch the incoming item
        logic init_step;  // write one link of the initial chain
        logic commit;     // apply the operation and load the result register
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_init;    // incoming item is an initialize
        logic init_done;  // every link of the chain is written
        logic out_free;   // result register can take a new result
    } ctl_sts_t;

endpackage

[rtl/core/fbfla_ctrl.sv]
// fbfla_ctrl: sequencing state machine of the free-list allocator.
// Depends on fbfla_pkg for the command and status structs.
`timescale 1ns / 1ps

module fbfla_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fbfla_pkg::ctl_sts_t sts,
    output fbfla_pkg::ctl_cmd_t cmd
);
    import fbfla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.init_step = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.is_init ? S_INIT : S_EXEC;
                end
            end
            S_INIT:
            begin
                if (sts.init_done)
                    state_next = S_EXEC;
                else
                    cmd.init_step = 1'b1;
            end
            S_EXEC:
            begin
                // hold here until the result register has room
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

[rtl/core/fbfla_datapath.sv]
// fbfla_datapath: config registers, next-pointer memory, head and counter,
// offset multiplier and result register. Depends on fbfla_pkg.
`timescale 1ns / 1ps

module fbfla_datapath #(
    parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [fbfla_pkg::FUNC_W-1:0]      func,
    input  logic [fbfla_pkg::INDEX_W-1:0]     block_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fbfla_pkg::STATUS_W-1:0]    status,
    output logic [fbfla_pkg::INDEX_W-1:0]     granted_index,
    output logic [fbfla_pkg::OFFSET_W-1:0]    granted_offset,
    output logic [fbfla_pkg::COUNT_W-1:0]     free_count,
    input  fbfla_pkg::ctl_cmd_t               cmd,
    output fbfla_pkg::ctl_sts_t               sts
);
    import fbfla_pkg::*;

    localparam int PTR_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W = $clog2(MAX_BLOCKS);
    localparam int RND_W  = BBYTES_W + 1;
    localparam logic [PTR_W-1:0] EMPTY = PTR_W'(MAX_BLOCKS);
    localparam logic [RND_W-1:0] WMASK = RND_W'(WORD_BYTES - 1);

    // configuration
    logic [NBLK_W-1:0]   num_blocks_reg;
    logic [BBYTES_W-1:0] block_bytes_reg;

    // list state
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] total_reg, total_next;
    logic [PTR_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] mem [MAX_BLOCKS];
    logic [PTR_W-1:0] rdata_reg;

    // latched item
    logic [FUNC_W-1:0]  func_reg;
    logic [INDEX_W-1:0] idx_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PTR_W-1:0]    gidx_reg, gidx_next;
    logic [OFFSET_W-1:0] goff_reg, goff_next;
    logic [PTR_W-1:0]    fcount_reg;

    logic [PTR_W-1:0]  pool_n;
    logic [PTR_W-1:0]  cnt_plus;
    logic [RND_W-1:0]  rounded;
    logic [31:0]       product;
    logic              range_err;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [PTR_W-1:0]  mem_wdata;

    // effective pool size, clamped to the memory depth
    assign pool_n = (32'(num_blocks_reg) > 32'(MAX_BLOCKS)) ? EMPTY : PTR_W'(num_blocks_reg);

    assign cnt_plus  = cnt_reg + 1'b1;
    assign rounded   = ({1'b0, block_bytes_reg} + WMASK) & ~WMASK;
    assign product   = 32'(head_reg) * 32'(rounded);
    assign range_err = (32'(idx_reg) >= 32'(pool_n));

    always_comb
    begin
        sts.is_init   = (func == FN_INIT);
        sts.init_done = (cnt_reg == pool_n);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // single write port: chain build or push of a freed block
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = cnt_reg[ADDR_W-1:0];
        mem_wdata = (cnt_plus < pool_n) ? cnt_plus : EMPTY;
        if (cmd.init_step)
            mem_we = 1'b1;
        else if (cmd.commit && func_reg == FN_FREE && !range_err)
        begin
            mem_we    = 1'b1;
            mem_addr  = ADDR_W'(idx_reg);
            mem_wdata = head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        // link of the current head, ready by the cycle after accept
        rdata_reg <= mem[head_reg[ADDR_W-1:0]];
    end

    always_comb
    begin
        head_next   = head_reg;
        total_next  = total_reg;
        status_next = ST_OK;
        gidx_next   = '0;
        goff_next   = '0;
        case (func_reg)
            FN_INIT:
            begin
                head_next  = (pool_n != '0) ? '0 : EMPTY;
                total_next = pool_n;
            end
            FN_ALLOC:
            begin
                if (head_reg >= EMPTY)
                    status_next = ST_EMPTY;
                else
                begin
                    gidx_next = head_reg;
                    head_next = (rdata_reg > EMPTY) ? EMPTY : rdata_reg;
                    if (total_reg != '0)
                        total_next = total_reg - 1'b1;
                    goff_next = OFFSET_W'(product + 32'(WORD_BYTES));
                end
            end
            FN_FREE:
            begin
                if (range_err)
                    status_next = ST_RANGE;
                else
                begin
                    head_next = PTR_W'(idx_reg);
                    if (total_reg < EMPTY)
                        total_next = total_reg + 1'b1;
                end
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.accept)
            cnt_next = '0;
        else if (cmd.init_step)
            cnt_next = cnt_plus;
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg  <= NBLK_RST;
            block_bytes_reg <= BBYTES_RST;
            head_reg        <= EMPTY;
            total_reg       <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_NUM_BLOCKS)
                num_blocks_reg <= NBLK_W'(cfg_data);
            if (cfg_we && cfg_index == CFG_BLOCK_BYTES)
                block_bytes_reg <= cfg_data;
            if (cmd.commit)
            begin
                head_reg  <= head_next;
                total_reg <= total_next;
            end
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func;
            idx_reg  <= block_index;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            gidx_reg   <= gidx_next;
            goff_reg   <= goff_next;
            fcount_reg <= total_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_index  = INDEX_W'(gidx_reg);
    assign granted_offset = goff_reg;
    assign free_count     = COUNT_W'(fcount_reg);

endmodule

[rtl/core/fixed_block_free_list_allocator.sv]
// fixed_block_free_list_allocator: top level of the LIFO free-list allocator.
// Depends on fbfla_pkg, fbfla_ctrl and fbfla_datapath.
`timescale 1ns / 1ps

// channel   handshake               payload
// --------  ----------------------  ------------------------------------------
// in        in_valid / in_ready     func, block_index
// out       out_valid / out_ready   status, granted_index, granted_offset,
//                                   free_count
// cfg       cfg_we (no wait)        cfg_index, cfg_data
//
// allocate, free and the reserved op step through accept, then commit; the
// next-pointer memory read of the head is registered at the accept edge
// initialize steps through accept, one memory write per link, a final pass
// to leave the chain build, then commit (pool size is num_blocks clamped to
// MAX_BLOCKS)
// one item is in work at a time; a new item is taken while a result waits
// in the output register, and commit stalls only if that register is full
// reset: pool empty, free count zero, next-pointer memory left unwritten

module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0]  cfg_data,
    // item input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fbfla_pkg::FUNC_W-1:0]      func,
    input  logic [fbfla_pkg::INDEX_W-1:0]     block_index,
    // result output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fbfla_pkg::STATUS_W-1:0]    status,
    output logic [fbfla_pkg::INDEX_W-1:0]     granted_index,
    output logic [fbfla_pkg::OFFSET_W-1:0]    granted_offset,
    output logic [fbfla_pkg::COUNT_W-1:0]     free_count
);
    import fbfla_pkg::*;

    // command and status between sequencer and datapath
    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // sequencer: idle, chain build, commit
    fbfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // list storage, arithmetic and the result register
    fbfla_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .block_index    (block_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_index  (granted_index),
        .granted_offset (granted_offset),
        .free_count     (free_count),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

[rtl/core/fbfla_checker.sv]
// fbfla_checker: port-level assertions for the free-list allocator, bound
// to the top level. Depends on fbfla_pkg.
`timescale 1ns / 1ps

module fbfla_checker #(
    parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [fbfla_pkg::STATUS_W-1:0]    status,
    input logic [fbfla_pkg::INDEX_W-1:0]     granted_index,
    input logic [fbfla_pkg::OFFSET_W-1:0]    granted_offset,
    input logic [fbfla_pkg::COUNT_W-1:0]     free_count
);
    import fbfla_pkg::*;

    localparam logic [OFFSET_W-1:0] ALIGN_MASK = OFFSET_W'(WORD_BYTES - 1);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(granted_index) && $stable(granted_offset) && $stable(free_count))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

    // an error result reports zero index and offset
    a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> granted_index == '0 && granted_offset == '0)
        else $error("index or offset set on an error result");

    // offsets are word aligned
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (granted_offset & ALIGN_MASK) == '0)
        else $error("granted offset not word aligned");

    // counter never passes the pool depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(free_count) <= 32'(MAX_BLOCKS))
        else $error("free count above pool depth");

endmodule

bind fixed_block_free_list_allocator fbfla_checker #(
    .MAX_BLOCKS (MAX_BLOCKS)
) u_fbfla_checker (.*);
